// ===== rtl/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared widths, codes and record types of the preemptive EDF scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

    // Default table depth
    localparam int SLOTS_DEF = 16;

    // Field widths
    localparam int TASK_W   = 8;
    localparam int BURST_W  = 16;
    localparam int TIME_W   = 32;
    localparam int FACTOR_W = 4;
    localparam int PROD_W   = FACTOR_W + BURST_W;
    localparam int STATUS_W = 3;

    // Register port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int REGI_W = ADDR_W - 2;
    localparam logic [REGI_W-1:0]   REG_FACTOR   = '0;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(2);

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Operation codes
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_RAN      = 3'd0,
        ST_IDLE     = 3'd1,
        ST_ACCEPTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_ZERO     = 3'd4
    } t_status;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [BURST_W-1:0] remaining;
        logic [TIME_W-1:0]  deadline;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // One result transfer
    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [TASK_W-1:0]  ran_task;
        logic               completed;
        logic [TIME_W-1:0]  finish_time;
        logic [BURST_W-1:0] left_units;
    } t_result;

endpackage

// ===== rtl/edf_ram.sv =====
// ----------------------------------------------------------------------------
// EDF generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/edf_cfg.sv =====
// ----------------------------------------------------------------------------
// EDF configuration registers
// APB-style register port holding the deadline factor.
// ----------------------------------------------------------------------------
module edf_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [edf_pkg::ADDR_W-1:0]  paddr,
    input  logic [edf_pkg::DATA_W-1:0]  pwdata,
    output logic [edf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [edf_pkg::FACTOR_W-1:0] o_factor
);
    import edf_pkg::*;

    logic [FACTOR_W-1:0] r_factor;
    logic [REGI_W-1:0]   w_index;
    logic                w_write;

    // word index, byte offset ignored
    assign w_index = paddr[ADDR_W-1:2];
    assign w_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
        end else if (w_write && (w_index == REG_FACTOR)) begin
            r_factor <= pwdata[FACTOR_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (w_index == REG_FACTOR) begin
            prdata = {{(DATA_W-FACTOR_W){1'b0}}, r_factor};
        end
    end

    assign pready   = 1'b1;
    assign o_factor = r_factor;

endmodule

// ===== rtl/edf_seq.sv =====
// ----------------------------------------------------------------------------
// EDF sequencer
// Walks the slot table one entry per cycle: free-slot search on arrive,
// minimum-deadline search through one shared comparator on tick, then
// writes the entry back and issues the result.
// ----------------------------------------------------------------------------
module edf_seq #(
    parameter int SLOTS = edf_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_operation,
    input  logic [edf_pkg::TASK_W-1:0]    i_task_id,
    input  logic [edf_pkg::BURST_W-1:0]   i_burst,
    input  logic [edf_pkg::FACTOR_W-1:0]  i_factor,
    output logic                          o_ram_we,
    output logic [$clog2(SLOTS)-1:0]      o_ram_waddr,
    output edf_pkg::t_slot                o_ram_wdata,
    output logic [$clog2(SLOTS)-1:0]      o_ram_raddr,
    input  edf_pkg::t_slot                i_ram_rdata,
    output edf_pkg::t_result              o_result
);
    import edf_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_WRITE,
        S_SCAN,
        S_LAST,
        S_UPDATE
    } t_state;

    // control state
    t_state             r_state,  n_state;
    logic [TIME_W-1:0]  r_now,    n_now;
    logic [SLOTS-1:0]   r_valid,  n_valid;
    logic               r_cvld,   n_cvld;
    logic               r_found,  n_found;
    t_result            r_result, n_result;

    // payload
    logic [IDX_W-1:0]   r_idx,      n_idx;
    logic [IDX_W-1:0]   r_cidx,     n_cidx;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    t_slot              r_best,     n_best;
    logic [TASK_W-1:0]  r_task_id,  n_task_id;
    logic [BURST_W-1:0] r_burst,    n_burst;
    logic [PROD_W-1:0]  r_prod,     n_prod;

    logic               w_take;
    logic [TIME_W:0]    w_sum;
    logic [TIME_W-1:0]  w_deadline;
    logic [TIME_W-1:0]  w_now_inc;
    logic [BURST_W-1:0] w_rem;
    logic [PROD_W-1:0]  w_prod;

    // factor times burst, registered at accept
    assign w_prod = PROD_W'(i_factor) * PROD_W'(i_burst);

    // deadline = now + product, saturating
    assign w_sum      = {1'b0, r_now} + {{(TIME_W+1-PROD_W){1'b0}}, r_prod};
    assign w_deadline = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];

    assign w_now_inc = (r_now == TIME_MAX) ? r_now : r_now + 1'b1;
    assign w_rem     = (r_best.remaining != '0) ? r_best.remaining - 1'b1 : '0;

    // shared comparator: strict less keeps the lowest slot on ties
    assign w_take = r_cvld && r_valid[r_cidx] &&
                    (!r_found || (i_ram_rdata.deadline < r_best.deadline));

    // slot memory access
    assign o_ram_raddr = r_idx;
    assign o_ram_we    = (r_state == S_WRITE) || ((r_state == S_UPDATE) && r_found);
    assign o_ram_waddr = (r_state == S_WRITE) ? r_idx : r_best_idx;

    always_comb begin
        if (r_state == S_WRITE) begin
            o_ram_wdata.task_id   = r_task_id;
            o_ram_wdata.remaining = r_burst;
            o_ram_wdata.deadline  = w_deadline;
        end else begin
            o_ram_wdata.task_id   = r_best.task_id;
            o_ram_wdata.remaining = w_rem;
            o_ram_wdata.deadline  = r_best.deadline;
        end
    end

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_valid    = r_valid;
        n_cvld     = 1'b0;
        n_found    = r_found;
        n_result   = r_result;
        n_result.valid = 1'b0;
        n_idx      = r_idx;
        n_cidx     = r_cidx;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_task_id  = r_task_id;
        n_burst    = r_burst;
        n_prod     = r_prod;

        // running minimum of the tick scan
        if (w_take) begin
            n_found    = 1'b1;
            n_best     = i_ram_rdata;
            n_best_idx = r_cidx;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_idx     = '0;
                    n_task_id = i_task_id;
                    n_burst   = i_burst;
                    n_prod    = w_prod;
                    if (i_operation == OP_TICK) begin
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end else if (i_burst == '0) begin
                        n_result.valid       = 1'b1;
                        n_result.status      = ST_ZERO;
                        n_result.ran_task    = i_task_id;
                        n_result.completed   = 1'b0;
                        n_result.finish_time = r_now;
                        n_result.left_units  = '0;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                // lowest free slot, one valid bit per cycle
                if (!r_valid[r_idx]) begin
                    n_state = S_WRITE;
                end else if (r_idx == LAST) begin
                    n_result.valid       = 1'b1;
                    n_result.status      = ST_FULL;
                    n_result.ran_task    = r_task_id;
                    n_result.completed   = 1'b0;
                    n_result.finish_time = r_now;
                    n_result.left_units  = '0;
                    n_state              = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WRITE: begin
                n_valid[r_idx]       = 1'b1;
                n_result.valid       = 1'b1;
                n_result.status      = ST_ACCEPTED;
                n_result.ran_task    = r_task_id;
                n_result.completed   = 1'b0;
                n_result.finish_time = r_now;
                n_result.left_units  = r_burst;
                n_state              = S_IDLE;
            end
            S_SCAN: begin
                // issue one read per cycle, compare it the cycle after
                n_cvld = 1'b1;
                n_cidx = r_idx;
                if (r_idx == LAST) begin
                    n_state = S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_now                = w_now_inc;
                n_result.valid       = 1'b1;
                n_result.finish_time = w_now_inc;
                if (r_found) begin
                    n_result.status     = ST_RAN;
                    n_result.ran_task   = r_best.task_id;
                    n_result.completed  = (w_rem == '0);
                    n_result.left_units = w_rem;
                    if (w_rem == '0) begin
                        n_valid[r_best_idx] = 1'b0;
                    end
                end else begin
                    n_result.status     = ST_IDLE;
                    n_result.ran_task   = '0;
                    n_result.completed  = 1'b0;
                    n_result.left_units = '0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_valid  <= '0;
            r_cvld   <= 1'b0;
            r_found  <= 1'b0;
            r_result <= '0;
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_valid    <= n_valid;
            r_cvld     <= n_cvld;
            r_found    <= n_found;
            r_result   <= n_result;
            r_idx      <= n_idx;
            r_cidx     <= n_cidx;
            r_best_idx <= n_best_idx;
            r_best     <= n_best;
            r_task_id  <= n_task_id;
            r_burst    <= n_burst;
            r_prod     <= n_prod;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_result = r_result;

endmodule

// ===== rtl/edf_preemptive_scheduler.sv =====
// ----------------------------------------------------------------------------
// Preemptive EDF scheduler
// Task table of SLOTS entries; arrive stores a task, tick runs the ready task
// with the earliest deadline for one time unit.
// ----------------------------------------------------------------------------
// Timing: an item is taken when start is high and busy is low; busy then
// stays high until the result is issued. On a tick the slot memory is
// read one entry per cycle and each entry goes through one deadline
// comparator, then the chosen entry is written back. An arrive with a
// nonzero burst walks the valid bits to the lowest free slot and then, if
// one is free, forms the deadline and writes the entry; an arrive with a
// zero burst is answered the cycle after it is taken and never raises
// busy. Every result is shown for exactly one cycle with o_valid high and
// cannot be held off, so the receiver must capture it then. The user must
// write the deadline factor through the register port only while the
// block is not busy; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module edf_preemptive_scheduler #(
    parameter int SLOTS = edf_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic [edf_pkg::TASK_W-1:0]   i_task_id,
    input  logic [edf_pkg::BURST_W-1:0]  i_burst,
    // result channel
    output logic                         o_valid,
    output logic [edf_pkg::STATUS_W-1:0] o_status,
    output logic [edf_pkg::TASK_W-1:0]   o_ran_task,
    output logic                         o_completed,
    output logic [edf_pkg::TIME_W-1:0]   o_finish_time,
    output logic [edf_pkg::BURST_W-1:0]  o_left_units,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [edf_pkg::ADDR_W-1:0]   paddr,
    input  logic [edf_pkg::DATA_W-1:0]   pwdata,
    output logic [edf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import edf_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [FACTOR_W-1:0] w_factor;
    logic                w_ram_we;
    logic [IDX_W-1:0]    w_ram_waddr;
    logic [IDX_W-1:0]    w_ram_raddr;
    t_slot               w_ram_wdata;
    t_slot               w_ram_rdata;
    t_result             w_result;

    edf_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_factor (w_factor)
    );

    edf_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_operation (i_operation),
        .i_task_id   (i_task_id),
        .i_burst     (i_burst),
        .i_factor    (w_factor),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_result    (w_result)
    );

    // slot table: task, remaining units, deadline
    edf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // result fields
    assign o_valid       = w_result.valid;
    assign o_status      = w_result.status;
    assign o_ran_task    = w_result.ran_task;
    assign o_completed   = w_result.completed;
    assign o_finish_time = w_result.finish_time;
    assign o_left_units  = w_result.left_units;

endmodule

// ===== rtl/edf_checker.sv =====
// ----------------------------------------------------------------------------
// EDF scheduler checker
// Port-level assertions on the command/result behavior, bound to the top.
// ----------------------------------------------------------------------------
module edf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         i_operation,
    input logic [edf_pkg::TASK_W-1:0]   i_task_id,
    input logic [edf_pkg::BURST_W-1:0]  i_burst,
    input logic                         o_valid,
    input logic [edf_pkg::STATUS_W-1:0] o_status,
    input logic [edf_pkg::TASK_W-1:0]   o_ran_task,
    input logic                         o_completed,
    input logic [edf_pkg::TIME_W-1:0]   o_finish_time,
    input logic [edf_pkg::BURST_W-1:0]  o_left_units
);
    import edf_pkg::*;

    logic w_acc;
    logic w_zero_arrive;

    assign w_acc         = start && !busy;
    assign w_zero_arrive = (i_operation == OP_ARRIVE) && (i_burst == '0);

    // a result is only issued once the block has gone idle
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result transfer while busy");

    // zero burst is answered at once with its own task id
    a_zero_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_zero_arrive |=>
            o_valid && (o_status == ST_ZERO) && (o_ran_task == $past(i_task_id)))
        else $error("zero burst not rejected next cycle");

    // every other item raises busy instead of being answered at once
    a_multi_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !w_zero_arrive |=> busy && !o_valid)
        else $error("multi-cycle item finished early");

    // completion means the running task has nothing left
    a_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_completed |-> (o_status == ST_RAN) && (o_left_units == '0))
        else $error("completion with units left");

    // an idle tick reports no task
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_IDLE) |->
            (o_ran_task == '0) && !o_completed && (o_left_units == '0) &&
            (o_finish_time != '0))
        else $error("idle tick result malformed");

endmodule

bind edf_preemptive_scheduler edf_checker u_edf_checker (.*);

// ===== verif/tb_edf_preemptive_scheduler.sv =====
// ----------------------------------------------------------------------------
// EDF scheduler testbench
// Drives arrive and tick commands through the start/busy handshake in random
// bursts and checks every result strobe against a local EDF table predictor.
// The deadline factor is changed between phases over the APB port, with a
// read-back of each write.
// ----------------------------------------------------------------------------
module tb_edf_preemptive_scheduler;
    import edf_pkg::*;

    localparam int SLOTS    = SLOTS_DEF;
    localparam int HALF_PER = 5;
    localparam int RUN_LEN  = 383;
    localparam int BIG_CAP  = 5;

    // One command transfer
    typedef struct {
        logic               op;
        logic [TASK_W-1:0]  task_id;
        logic [BURST_W-1:0] burst;
    } t_cmd;

    // One result transfer as predicted
    typedef struct {
        t_status            status;
        logic [TASK_W-1:0]  ran_task;
        logic               completed;
        logic [TIME_W-1:0]  finish_time;
        logic [BURST_W-1:0] left_units;
    } t_sched_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_operation = OP_ARRIVE;
    logic [TASK_W-1:0]     i_task_id = '0;
    logic [BURST_W-1:0]    i_burst = '0;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [TASK_W-1:0]     o_ran_task;
    logic                  o_completed;
    logic [TIME_W-1:0]     o_finish_time;
    logic [BURST_W-1:0]    o_left_units;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Commands waiting to be sent and results waiting to arrive
    t_cmd          cmd_queue[$];
    t_sched_result awaited_results[$];

    // Predictor copy of the task table
    logic                tbl_valid [SLOTS];
    logic [TASK_W-1:0]   tbl_task  [SLOTS];
    logic [BURST_W-1:0]  tbl_left  [SLOTS];
    logic [TIME_W-1:0]   tbl_due   [SLOTS];
    logic [TIME_W-1:0]   cur_time;
    logic [FACTOR_W-1:0] cur_factor;

    int err_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int big_count = 0;

    edf_preemptive_scheduler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_task_id     (i_task_id),
        .i_burst       (i_burst),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_ran_task    (o_ran_task),
        .o_completed   (o_completed),
        .o_finish_time (o_finish_time),
        .o_left_units  (o_left_units),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #HALF_PER i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
        err_count++;
    endtask

    // Predict the result of one command and update the table copy
    function automatic t_sched_result edf_step(t_cmd c);
        t_sched_result r;
        int pick;
        logic [63:0] due;
        pick          = -1;
        r.status      = ST_IDLE;
        r.ran_task    = '0;
        r.completed   = 1'b0;
        r.finish_time = cur_time;
        r.left_units  = '0;
        if (c.op == OP_ARRIVE) begin
            r.ran_task = c.task_id;
            if (c.burst == '0) begin
                r.status = ST_ZERO;
            end else begin
                // lowest free slot
                for (int i = 0; i < SLOTS; i++)
                    if (!tbl_valid[i] && pick < 0) pick = i;
                if (pick < 0) begin
                    r.status = ST_FULL;
                end else begin
                    due = 64'(cur_time) + 64'(cur_factor) * 64'(c.burst);
                    if (due > 64'(TIME_MAX)) due = 64'(TIME_MAX);
                    tbl_valid[pick] = 1'b1;
                    tbl_task[pick]  = c.task_id;
                    tbl_left[pick]  = c.burst;
                    tbl_due[pick]   = due[TIME_W-1:0];
                    r.status        = ST_ACCEPTED;
                    r.left_units    = c.burst;
                end
            end
        end else begin
            // earliest deadline, ties to the lowest slot
            for (int i = 0; i < SLOTS; i++)
                if (tbl_valid[i] && (pick < 0 || tbl_due[i] < tbl_due[pick])) pick = i;
            if (cur_time != TIME_MAX) cur_time = cur_time + 1'b1;
            r.finish_time = cur_time;
            if (pick >= 0) begin
                r.status   = ST_RAN;
                r.ran_task = tbl_task[pick];
                if (tbl_left[pick] != '0) tbl_left[pick] = tbl_left[pick] - 1'b1;
                r.left_units = tbl_left[pick];
                if (tbl_left[pick] == '0) begin
                    tbl_valid[pick] = 1'b0;
                    r.completed     = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Command driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin : driver
        t_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                c.op      = i_operation;
                c.task_id = i_task_id;
                c.burst   = i_burst;
                awaited_results.push_back(edf_step(c));
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    c = cmd_queue.pop_front();
                    i_operation <= c.op;
                    i_task_id   <= c.task_id;
                    i_burst     <= c.burst;
                    start       <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every strobe is compared with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_sched_result want;
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with none awaited, status", 32'(o_status), '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_ran_task !== want.ran_task)
                    report_mismatch("ran_task", 32'(o_ran_task), 32'(want.ran_task));
                if (o_completed !== want.completed)
                    report_mismatch("completed", 32'(o_completed), 32'(want.completed));
                if (o_finish_time !== want.finish_time)
                    report_mismatch("finish_time", o_finish_time, want.finish_time);
                if (o_left_units !== want.left_units)
                    report_mismatch("left_units", 32'(o_left_units), 32'(want.left_units));
            end
        end
    end

    function automatic void push_cmd(logic op, logic [TASK_W-1:0] id,
                                     logic [BURST_W-1:0] burst);
        t_cmd c;
        c.op      = op;
        c.task_id = id;
        c.burst   = burst;
        cmd_queue.push_back(c);
    endfunction

    // Mostly short bursts; long ones are capped since they hold a slot for good
    function automatic logic [BURST_W-1:0] pick_burst();
        int r;
        r = $urandom_range(0, 199);
        if (r < 7) return '0;
        if (r == 199 && big_count < BIG_CAP) begin
            big_count++;
            return BURST_W'($urandom_range(1024, 65535));
        end
        if (r < 140) return BURST_W'($urandom_range(1, 6));
        return BURST_W'($urandom_range(1, 40));
    endfunction

    // Random commands; the arrive share changes per stretch to fill and drain
    task automatic add_random(input int n);
        int arrive_pct;
        arrive_pct = 30;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: arrive_pct = 10;
                    1: arrive_pct = 25;
                    default: arrive_pct = 55;
                endcase
            end
            if ($urandom_range(0, 99) < arrive_pct)
                push_cmd(OP_ARRIVE, TASK_W'($urandom), pick_burst());
            else
                push_cmd(OP_TICK, TASK_W'($urandom), BURST_W'($urandom));
        end
    endtask

    // Wait until no command or result is outstanding
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || start || busy || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
    endtask

    // APB write of the deadline factor, then read it back
    task automatic set_factor(input logic [FACTOR_W-1:0] value);
        logic [DATA_W-1:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_FACTOR, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        cur_factor = value;
        // read access
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== DATA_W'(value))
            report_mismatch("deadline_factor read", rd, DATA_W'(value));
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_task[i]  = '0;
            tbl_left[i]  = '0;
            tbl_due[i]   = '0;
        end
        cur_time   = '0;
        cur_factor = FACTOR_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle tick, zero burst, longest burst, ties, full table
        push_cmd(OP_TICK, 8'h00, 16'h0000);
        push_cmd(OP_ARRIVE, 8'hFF, 16'h0000);
        push_cmd(OP_ARRIVE, 8'h00, 16'hFFFF);
        push_cmd(OP_ARRIVE, 8'hFF, 16'h0001);
        push_cmd(OP_TICK, 8'hFF, 16'hFFFF);
        push_cmd(OP_TICK, 8'h00, 16'h0000);
        for (int k = 0; k < SLOTS - 1; k++)
            push_cmd(OP_ARRIVE, TASK_W'(8'h10 + k), (k < 6) ? 16'd2 : BURST_W'(k - 4));
        push_cmd(OP_ARRIVE, 8'hA5, 16'h0003);
        push_cmd(OP_ARRIVE, 8'h5A, 16'h0000);
        push_cmd(OP_TICK, 8'h00, 16'h0000);
        push_cmd(OP_TICK, 8'h00, 16'h0000);
        add_random(RUN_LEN);
        wait_idle();

        // Phases under other factors: maximum, one, zero, then a random one
        set_factor(4'd15);
        add_random(RUN_LEN);
        wait_idle();
        set_factor(4'd1);
        add_random(RUN_LEN);
        wait_idle();
        set_factor(4'd0);
        add_random(RUN_LEN / 2);
        wait_idle();
        set_factor(FACTOR_W'($urandom_range(3, 14)));
        add_random(RUN_LEN);
        wait_idle();

        if (err_count == 0)
            $display("edf_preemptive_scheduler: match");
        else
            $display("edf_preemptive_scheduler: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("edf_preemptive_scheduler: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/edf_pkg.sv
rtl/edf_ram.sv
rtl/edf_cfg.sv
rtl/edf_seq.sv
rtl/edf_preemptive_scheduler.sv
rtl/edf_checker.sv
verif/tb_edf_preemptive_scheduler.sv
